@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by the checker module only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define VFV_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voxel face visibility check failed");

// Next-cycle implication, disabled while reset is high.
`define VFV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voxel face visibility check failed");

`endif

@@ rtl/vfv_pkg.sv @@
// Shared types, codes and default sizes of the voxel face visibility block.
// Depends on nothing; imported by every module of the block.
package vfv_pkg;

  localparam int COORD_W       = 5;
  localparam int OUT_TYPE_W    = 8;
  localparam int IN_TYPE_W     = 8;
  localparam int EXT_W         = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int DEF_GRID_DIM  = 32;
  localparam int DEF_TYPE_BITS = 8;

  localparam logic [EXT_W-1:0] EXT_RESET = 5'd25;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [COORD_W-1:0]   x_coord;
    logic [COORD_W-1:0]   y_coord;
    logic [COORD_W-1:0]   z_coord;
    logic [IN_TYPE_W-1:0] new_type;
  } vfv_item_t;

  typedef struct packed {
    logic [OUT_TYPE_W-1:0] block_type;
    logic                  solid;
    logic                  face_top;
    logic                  face_left;
    logic                  face_front;
    logic                  face_right;
    logic                  face_back;
    logic                  face_bottom;
  } vfv_result_t;

  typedef struct packed {
    logic [EXT_W-1:0] width;
    logic [EXT_W-1:0] height;
    logic [EXT_W-1:0] depth;
  } vfv_extents_t;

  typedef enum logic [2:0] {
    STEP_CENTER,
    STEP_TOP,
    STEP_LEFT,
    STEP_FRONT,
    STEP_RIGHT,
    STEP_BACK,
    STEP_BOTTOM
  } vfv_step_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN
  } vfv_state_t;

endpackage

@@ rtl/voxel_face_visibility.sv @@
// Top level of the voxel face visibility block: sequencer, voxel store, registers.
// Depends on vfv_pkg and on vfv_nbr for neighbor addressing.
//
// Usage. An item is taken at a rising edge where start is high and busy is low.
// Its op field selects a write of new_type at (x,y,z) or a plain query. Either
// kind returns one result beat: done is high for exactly one cycle with the
// result fields valid, and the receiver must take it then; it cannot stall.
//
// Sequence. Every item walks the voxel itself and its six neighbors through the one
// port of the store: a write step if the item writes, one read step per lookup, then
// a drain step to absorb the last read, from which done is registered. The next item
// may be started in the cycle where done is high.
//
// Reset. After rst the store is swept to air, one entry per cycle, through every one
// of its GRID_DIM**3 entries; busy stays high meanwhile.
// The extent registers reset to 25 and can be written at any time through the
// cfg channel, which is always ready; an index beyond the depth register is
// dropped without effect.
module voxel_face_visibility import vfv_pkg::*; #(
  parameter int GRID_DIM  = DEF_GRID_DIM,
  parameter int TYPE_BITS = DEF_TYPE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  vfv_item_t            item,
  output logic                 done,
  output vfv_result_t          result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [EXT_W-1:0]     cfg_data
);

  localparam int CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(CELLS);

  // Control state.
  vfv_state_t state, state_next;
  vfv_step_t  step, step_next;
  logic [AW-1:0] clr_cnt;

  // Latched item and configuration.
  vfv_item_t    item_q;
  vfv_extents_t ext;

  // Store port.
  logic [TYPE_BITS-1:0] mem [CELLS];
  logic                 mem_en;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [TYPE_BITS-1:0] mem_wdata;
  logic [TYPE_BITS-1:0] rd_data;

  // Read return tracking: which step the registered read data belongs to.
  logic      cap_valid;
  vfv_step_t cap_step;
  logic      cap_use;

  // Gathered per-item results.
  logic [TYPE_BITS-1:0] center_type;
  logic                 f_top, f_left, f_front, f_right, f_back;
  logic                 f_bottom_live;
  logic                 solid_now;
  vfv_result_t          result_next;

  logic [AW-1:0] nbr_addr;
  logic          nbr_use;

  assign busy      = state != ST_IDLE;
  assign cfg_ready = 1'b1;

  vfv_nbr #(
    .GRID_DIM (GRID_DIM),
    .AW       (AW)
  ) u_nbr (
    .step     (step),
    .item     (item_q),
    .ext      (ext),
    .addr     (nbr_addr),
    .use_read (nbr_use)
  );

  // Extent registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ext.width  <= EXT_RESET;
      ext.height <= EXT_RESET;
      ext.depth  <= EXT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  ext.width  <= cfg_data;
        CFG_HEIGHT: ext.height <= cfg_data;
        CFG_DEPTH:  ext.depth  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: next state and store port control.
  always_comb begin
    state_next = state;
    step_next  = step;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = nbr_addr;
    mem_wdata  = TYPE_BITS'(item_q.new_type);
    unique case (state)
      ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = '0;
        if (clr_cnt == AW'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        step_next = STEP_CENTER;
        if (start) begin
          state_next = (item.op == OP_WRITE) ? ST_WRITE : ST_READ;
        end
      end
      ST_WRITE: begin
        // Step is at the voxel itself, so the use flag is the in-grid test.
        mem_en     = nbr_use;
        mem_we     = nbr_use;
        state_next = ST_READ;
      end
      ST_READ: begin
        mem_en = nbr_use;
        if (step == STEP_BOTTOM) begin
          state_next = ST_DRAIN;
        end else begin
          step_next = vfv_step_t'(step + 3'd1);
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      step    <= STEP_CENTER;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      item_q <= item;
    end
  end

  // Single-port voxel store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) begin
        mem[mem_addr] <= mem_wdata;
      end else begin
        rd_data <= mem[mem_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else begin
      cap_valid <= state == ST_READ;
    end
  end

  always_ff @(posedge clk) begin
    cap_step <= step;
    cap_use  <= nbr_use;
  end

  // Sort each returning read but the bottom one into the voxel type or one face bit.
  always_ff @(posedge clk) begin
    if (cap_valid) begin
      unique case (cap_step)
        STEP_CENTER: center_type <= cap_use ? rd_data : '0;
        STEP_TOP:    f_top       <= cap_use && (rd_data == '0);
        STEP_LEFT:   f_left      <= cap_use && (rd_data == '0);
        STEP_FRONT:  f_front     <= cap_use && (rd_data == '0);
        STEP_RIGHT:  f_right     <= cap_use && (rd_data == '0);
        STEP_BACK:   f_back      <= cap_use && (rd_data == '0);
        STEP_BOTTOM: ;
      endcase
    end
  end

  // The bottom neighbor's data arrives in the drain cycle and is used directly.
  assign f_bottom_live = cap_use && (rd_data == '0);
  assign solid_now     = center_type != '0;

  always_comb begin
    result_next.block_type  = OUT_TYPE_W'(center_type);
    result_next.solid       = solid_now;
    result_next.face_top    = solid_now && f_top;
    result_next.face_left   = solid_now && f_left;
    result_next.face_front  = solid_now && f_front;
    result_next.face_right  = solid_now && f_right;
    result_next.face_back   = solid_now && f_back;
    result_next.face_bottom = solid_now && f_bottom_live;
  end

  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= state == ST_DRAIN;
    end
  end

endmodule

@@ rtl/vfv_nbr.sv @@
// Neighbor address generator: maps a lookup step to a linear store address.
// Depends on vfv_pkg for the item, extents and step types.
module vfv_nbr import vfv_pkg::*; #(
  parameter int GRID_DIM = DEF_GRID_DIM,
  parameter int AW       = $clog2(GRID_DIM * GRID_DIM * GRID_DIM)
) (
  input  vfv_step_t    step,
  input  vfv_item_t    item,
  input  vfv_extents_t ext,
  output logic [AW-1:0] addr,
  output logic          use_read
);

  localparam int CW = $clog2(GRID_DIM);
  localparam int NW = ((CW > COORD_W) ? CW : COORD_W) + 1;

  logic [NW-1:0] xe, ye, ze;
  logic [NW-1:0] nx, ny, nz;
  logic          bound_ok;
  logic          in_grid;

  assign xe = NW'(item.x_coord);
  assign ye = NW'(item.y_coord);
  assign ze = NW'(item.z_coord);

  // The minus-side tests keep out of use the coordinate that wraps below zero.
  always_comb begin
    nx       = xe;
    ny       = ye;
    nz       = ze;
    bound_ok = 1'b1;
    unique case (step)
      STEP_CENTER: bound_ok = 1'b1;
      STEP_TOP: begin
        ny       = ye + NW'(1);
        bound_ok = (ye + NW'(1)) < NW'(ext.height);
      end
      STEP_LEFT: begin
        nx       = xe - NW'(1);
        bound_ok = xe != '0;
      end
      STEP_FRONT: begin
        nz       = ze - NW'(1);
        bound_ok = ze != '0;
      end
      STEP_RIGHT: begin
        nx       = xe + NW'(1);
        bound_ok = (xe + NW'(1)) < NW'(ext.width);
      end
      STEP_BACK: begin
        nz       = ze + NW'(1);
        bound_ok = (ze + NW'(1)) < NW'(ext.depth);
      end
      STEP_BOTTOM: begin
        ny       = ye - NW'(1);
        bound_ok = ye != '0;
      end
    endcase
  end

  assign in_grid  = (nx < NW'(GRID_DIM)) && (ny < NW'(GRID_DIM)) && (nz < NW'(GRID_DIM));
  assign use_read = in_grid && bound_ok;

  assign addr = AW'(nx) * AW'(GRID_DIM * GRID_DIM) + AW'(ny) * AW'(GRID_DIM) + AW'(nz);

endmodule

@@ rtl/vfv_checker.sv @@
// Port-level checks of the voxel face visibility block, bound to its top level.
// Depends on vfv_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module vfv_checker import vfv_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input vfv_result_t result
);

  logic any_face;

  assign any_face = result.face_top || result.face_left || result.face_front ||
                    result.face_right || result.face_back || result.face_bottom;

  // An accepted beat keeps the block busy in the following cycle.
  `VFV_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // A result beat lasts one cycle and is never followed at once by another.
  `VFV_ASSERT_NEXT(a_done_single, clk, rst, done, !done)

  // A result beat comes only out of a busy cycle.
  `VFV_ASSERT_IMPL(a_done_after_work, clk, rst, done, $past(busy))

  // Air or an off-grid voxel shows no faces.
  `VFV_ASSERT_IMPL(a_air_no_faces, clk, rst, done && !result.solid, !any_face)

endmodule

bind voxel_face_visibility vfv_checker u_vfv_checker (.*);

@@ sim/voxel_face_visibility_tb.sv @@
// Self-checking testbench for voxel_face_visibility: directed and random write/query beats,
// extent register phases, and a mirror of the voxel store that predicts every result.
// Depends on vfv_pkg and on the voxel_face_visibility RTL; needs nothing else.
module voxel_face_visibility_tb;
  import vfv_pkg::*;

  // Generous ceiling: it covers the clearing sweep after reset, then about 1250 beats,
  // each with its busy stretch and any random gap drawn before it.
  localparam int CYCLE_LIMIT = 400_000;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int DRAIN_CYCLES = 12;
  // The index port is two bits wide; the fourth code selects no register.
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam int GRID = DEF_GRID_DIM;
  localparam int TYPE_MASK = (1 << DEF_TYPE_BITS) - 1;

  // Shadow copy of the voxel store and the extent registers. Every accepted beat is applied
  // here and its expected result is queued; every done beat is checked against the oldest.
  class voxel_mirror;
    bit [7:0] cells [GRID*GRID*GRID];
    bit [EXT_W-1:0] ext_w, ext_h, ext_d;
    vfv_result_t expected_faces [$];
    int mismatches;
    int results_seen;

    function new();
      ext_w = EXT_RESET;
      ext_h = EXT_RESET;
      ext_d = EXT_RESET;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function bit in_grid(int x, int y, int z);
      return x >= 0 && x < GRID && y >= 0 && y < GRID && z >= 0 && z < GRID;
    endfunction

    function int cell_at(int x, int y, int z);
      return (x * GRID + y) * GRID + z;
    endfunction

    // A neighbor outside the grid never counts as air.
    function bit is_air(int x, int y, int z);
      if (!in_grid(x, y, z)) return 1'b0;
      return cells[cell_at(x, y, z)] == 0;
    endfunction

    function void set_extent(logic [CFG_IDX_W-1:0] idx, logic [EXT_W-1:0] value);
      case (idx)
        CFG_WIDTH: ext_w = value;
        CFG_HEIGHT: ext_h = value;
        CFG_DEPTH: ext_d = value;
        default: ;
      endcase
    endfunction

    function vfv_result_t faces_after(vfv_item_t beat);
      vfv_result_t r;
      int x, y, z;
      bit [7:0] t;
      x = beat.x_coord;
      y = beat.y_coord;
      z = beat.z_coord;
      if (beat.op == OP_WRITE && in_grid(x, y, z))
        cells[cell_at(x, y, z)] = 8'(beat.new_type & TYPE_MASK);
      t = in_grid(x, y, z) ? cells[cell_at(x, y, z)] : 8'd0;
      r = '0;
      r.block_type = t;
      r.solid = (t != 0);
      if (r.solid) begin
        if (y + 1 < ext_h) r.face_top = is_air(x, y + 1, z);
        if (x > 0) r.face_left = is_air(x - 1, y, z);
        if (z > 0) r.face_front = is_air(x, y, z - 1);
        if (x + 1 < ext_w) r.face_right = is_air(x + 1, y, z);
        if (z + 1 < ext_d) r.face_back = is_air(x, y, z + 1);
        if (y > 0) r.face_bottom = is_air(x, y - 1, z);
      end
      return r;
    endfunction

    function void apply_item(vfv_item_t beat);
      expected_faces.push_back(faces_after(beat));
    endfunction

    function int pending();
      return expected_faces.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at result %0d: %s", results_seen, what);
      mismatches++;
    endtask

    task match_result(vfv_result_t got);
      vfv_result_t want;
      results_seen++;
      if (expected_faces.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_faces.pop_front();
        if (got.block_type !== want.block_type)
          report_mismatch($sformatf("block_type got %0d want %0d",
                                    got.block_type, want.block_type));
        if (got.solid !== want.solid)
          report_mismatch($sformatf("solid got %b want %b", got.solid, want.solid));
        if (got.face_top !== want.face_top)
          report_mismatch($sformatf("face_top got %b want %b", got.face_top, want.face_top));
        if (got.face_left !== want.face_left)
          report_mismatch($sformatf("face_left got %b want %b",
                                    got.face_left, want.face_left));
        if (got.face_front !== want.face_front)
          report_mismatch($sformatf("face_front got %b want %b",
                                    got.face_front, want.face_front));
        if (got.face_right !== want.face_right)
          report_mismatch($sformatf("face_right got %b want %b",
                                    got.face_right, want.face_right));
        if (got.face_back !== want.face_back)
          report_mismatch($sformatf("face_back got %b want %b",
                                    got.face_back, want.face_back));
        if (got.face_bottom !== want.face_bottom)
          report_mismatch($sformatf("face_bottom got %b want %b",
                                    got.face_bottom, want.face_bottom));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  vfv_item_t item;
  logic done;
  vfv_result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [EXT_W-1:0] cfg_data;

  voxel_mirror tracker = new();
  bit gaps_on = 1'b1;
  int cycle_count = 0;

  voxel_face_visibility DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a run that never drains ends here as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Monitor. Everything is sampled at the rising edge, before the block's own updates land,
  // so the handshake conditions seen here are exactly the ones the block acts on. Config
  // writes only happen while nothing is in flight, so their order against beats is moot.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.match_result(result);
      if (cfg_valid && cfg_ready) tracker.set_extent(cfg_index, cfg_data);
      if (start && !busy) tracker.apply_item(item);
    end
  end

  function automatic vfv_item_t beat_of(logic op, int x, int y, int z, int t);
    vfv_item_t b;
    b.op = op;
    b.x_coord = x[COORD_W-1:0];
    b.y_coord = y[COORD_W-1:0];
    b.z_coord = z[COORD_W-1:0];
    b.new_type = t[IN_TYPE_W-1:0];
    return b;
  endfunction

  // Coordinates mostly gather in a small corner box or around the extent edge, so that
  // written voxels meet solid neighbors and the bound tests flip; the rest roam the grid.
  function automatic int pick_coord(int ext);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 3);
      4, 5: v = ext - 2 + $urandom_range(0, 3);
      6: v = $urandom_range(28, 31);
      default: v = $urandom_range(0, 31);
    endcase
    if (v < 0) v = 0;
    if (v > GRID - 1) v = GRID - 1;
    return v;
  endfunction

  function automatic vfv_item_t random_beat();
    int t;
    // About a third of writes store air, which carves holes that open faces again.
    t = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 255);
    return beat_of($urandom_range(0, 1) ? OP_QUERY : OP_WRITE, pick_coord(tracker.ext_w),
                   pick_coord(tracker.ext_h), pick_coord(tracker.ext_d), t);
  endfunction

  // Entered and left at a falling edge. Start stays high from one beat to the next unless
  // a gap is drawn, so it is never dropped and raised in the same step.
  task automatic send_item(input vfv_item_t beat);
    if (gaps_on && $urandom_range(0, 99) < 33) begin
      start = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    start = 1'b1;
    item = beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds start low until every expected result beat has come back.
  task automatic wait_results();
    start = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task automatic write_extent(input logic [CFG_IDX_W-1:0] idx, input logic [EXT_W-1:0] value);
    if ($urandom_range(0, 99) < 33) repeat ($urandom_range(1, 4)) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Extents change only with the block idle, i.e. with no result outstanding.
  task automatic set_extents(input int w, input int h, input int d);
    wait_results();
    write_extent(CFG_WIDTH, w[EXT_W-1:0]);
    write_extent(CFG_HEIGHT, h[EXT_W-1:0]);
    write_extent(CFG_DEPTH, d[EXT_W-1:0]);
  endtask

  task automatic random_phase(input int count, input bit with_pause);
    for (int i = 0; i < count; i++) begin
      // Once per run the sender holds off until the block has fully drained.
      if (with_pause && i == count / 2) wait_results();
      send_item(random_beat());
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed beats at the reset extents of 25. The first one waits out the clearing sweep.
    send_item(beat_of(OP_QUERY, 0, 0, 0, 0));
    send_item(beat_of(OP_WRITE, 1, 1, 1, 255));      // isolated solid: all six faces
    send_item(beat_of(OP_WRITE, 1, 2, 1, 1));        // stacked on it: bottom hidden
    send_item(beat_of(OP_QUERY, 1, 1, 1, 0));        // top now hidden
    send_item(beat_of(OP_WRITE, 0, 0, 0, 128));      // corner: no minus-side faces
    send_item(beat_of(OP_WRITE, 24, 24, 24, 7));     // last cell inside the extents
    send_item(beat_of(OP_WRITE, 23, 23, 23, 60));
    send_item(beat_of(OP_WRITE, 31, 31, 31, 85));    // beyond the extents: minus faces only
    send_item(beat_of(OP_WRITE, 31, 0, 31, 170));
    send_item(beat_of(OP_WRITE, 1, 1, 1, 0));        // back to air: no faces at all
    send_item(beat_of(OP_QUERY, 1, 2, 1, 0));
    send_item(beat_of(OP_QUERY, 30, 30, 30, 0));     // never written

    // A write to the unused index must leave the extents alone.
    wait_results();
    write_extent(CFG_NONE, 5'd0);
    send_item(beat_of(OP_QUERY, 23, 23, 23, 0));

    // Zero extents switch off every plus-side face.
    set_extents(0, 0, 0);
    send_item(beat_of(OP_WRITE, 0, 0, 0, 9));
    send_item(beat_of(OP_WRITE, 5, 5, 5, 1));
    send_item(beat_of(OP_QUERY, 24, 24, 24, 0));
    wait_results();
    write_extent(CFG_NONE, 5'd31);
    send_item(beat_of(OP_QUERY, 5, 5, 5, 0));

    // Random phases over a spread of extent settings, the extremes among them.
    set_extents(EXT_RESET, EXT_RESET, EXT_RESET);
    random_phase(ITEMS_PER_PHASE, 1'b0);

    // A long stretch with the sender never idling.
    set_extents(31, 31, 31);
    gaps_on = 1'b0;
    random_phase(ITEMS_PER_PHASE, 1'b0);
    gaps_on = 1'b1;

    set_extents(1, 1, 1);
    random_phase(ITEMS_PER_PHASE, 1'b1);

    set_extents($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
    random_phase(ITEMS_PER_PHASE, 1'b0);

    set_extents(0, 31, 7);
    random_phase(ITEMS_PER_PHASE, 1'b0);

    set_extents($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
    random_phase(ITEMS_PER_PHASE, 1'b0);

    // Drain, then leave room for any stray result beat to show up.
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));

    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
